/* src/pds_pkg.sv */
// shared types and constants for the proper divisor sum block
package pds_pkg;

    localparam int unsigned DefTableDepth = 65536;
    localparam int unsigned CountW        = 17;

    localparam logic ReqLoad    = 1'b0;
    localparam logic ReqCompute = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [15:0] entry_index;
        logic [31:0] prime_value;
        logic [63:0] number;
    } t_in_item;

    typedef struct packed {
        logic [63:0] number_echo;
        logic [63:0] divisor_sum;
        logic        wrapped;
    } t_out_item;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
        logic [31:0] remainder;
    } t_div_rsp;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [63:0] product;
        logic        ovf;
    } t_mul_rsp;

endpackage

/* src/pds_divider.sv */
// radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle
module pds_divider
    import pds_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy, n_busy;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_quo, n_quo;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_dvs, n_dvs;
    logic        r_done, n_done;
    logic [32:0] shifted;
    logic [33:0] diff;

    always_comb begin
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_done  = 1'b0;
        shifted = {r_rem, r_quo[63]};
        diff    = {1'b0, shifted} - {2'b00, r_dvs};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 7'd0;
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            if (!diff[33]) begin
                n_rem = diff[31:0];
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = shifted[31:0];
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

/* src/pds_multiplier.sv */
// 64 by 64 multiplier over four 32x32 partial products, with overflow detect
module pds_multiplier
    import pds_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic [2:0]   r_step, n_step;
    logic         r_busy, n_busy;
    logic         r_done, n_done;
    logic [63:0]  r_a, n_a, r_b, n_b;
    logic [127:0] r_acc, n_acc;
    logic [63:0]  r_pp;
    logic [31:0]  op_a, op_b;
    logic [127:0] pp_sh;

    always_comb begin
        op_a = r_step[0] ? r_a[63:32] : r_a[31:0];
        op_b = r_step[1] ? r_b[63:32] : r_b[31:0];
    end

    always_comb begin
        n_step = r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        // partial product of the previous step lands here
        case (r_step)
            3'd1:    pp_sh = {64'd0, r_pp};
            3'd2:    pp_sh = {32'd0, r_pp, 32'd0};
            3'd3:    pp_sh = {32'd0, r_pp, 32'd0};
            3'd4:    pp_sh = {r_pp, 64'd0};
            default: pp_sh = '0;
        endcase
        if (i_req.start) begin
            n_busy = 1'b1;
            n_step = 3'd0;
            n_a    = i_req.a;
            n_b    = i_req.b;
            n_acc  = '0;
        end else if (r_busy) begin
            n_acc  = r_acc + pp_sh;
            n_step = r_step + 3'd1;
            if (r_step == 3'd4) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_pp  <= op_a * op_b;
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc[63:0];
    assign o_rsp.ovf     = |r_acc[127:64];

endmodule

/* src/pds_table.sv */
// prime table memory with registered read
module pds_table
    import pds_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_wr_addr,
    input  logic [31:0]                    i_wr_data,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_rd_addr,
    output logic [31:0]                    o_rd_data
);

    logic [31:0] r_mem [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

/* src/proper_divisor_sum.sv */
// top level of the proper divisor sum block
// Computes the sum of the proper divisors of a 64-bit number by trial division
// over a loaded prime table. A load transaction writes one table entry. A
// compute transaction walks the table in order under a small sequencer that
// shares one 64/32-bit bit-serial divider and one 64x64 multiplier built from
// four 32x32 products. A table entry that does not divide costs a read, a p*p
// check and one division. Each power of p found adds one more division, with
// the power and term update overlapped, and a prime that divides adds a
// multiply into sigma. The walk ends at the first p with p*p above the
// cofactor or when the configured entry count is used up, and a cofactor left
// above one is then multiplied into sigma as a prime. Input is stalled while a
// number is in progress; the result sits in an output register until taken.
module proper_divisor_sum
    import pds_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in_item          i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out_item         o_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CountW-1:0] i_cfg_data
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned IW = AW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_WAIT, S_CHK, S_DIV, S_POW, S_TERM, S_SIG,
        S_NEXT, S_LEFT, S_FIN, S_OUT
    } t_state;

    t_state          r_state;
    logic [CountW-1:0] r_count;
    logic [IW-1:0]   r_idx;
    logic [IW-1:0]   limit;
    logic [63:0]     r_n, r_rest, r_sigma, r_term, r_power;
    logic [31:0]     r_p;
    logic            r_ovf;
    logic            r_found;
    logic            r_o_valid;
    t_out_item       r_o_data;
    logic [31:0]     rd_data;
    t_div_req        div_req;
    t_div_rsp        div_rsp;
    t_mul_req        mul_req;
    t_mul_rsp        mul_rsp;
    logic            accept;
    logic            wr_en;
    logic [64:0]     sum;
    logic [1:0]      r_mphase;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_stall     = (r_state != S_IDLE);
    assign accept      = i_valid && (r_state == S_IDLE);
    assign wr_en       = accept && (i_data.req_type == ReqLoad)
                         && ({16'd0, i_data.entry_index} < 32'(TABLE_DEPTH));
    assign limit       = (32'(r_count) > 32'(TABLE_DEPTH)) ? IW'(TABLE_DEPTH)
                                                           : IW'(r_count);

    pds_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(AW'(i_data.entry_index)),
        .i_wr_data(i_data.prime_value),
        .i_rd_addr(r_idx[AW-1:0]),
        .o_rd_data(rd_data)
    );

    pds_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));
    pds_multiplier u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mul_req), .o_rsp(mul_rsp));

    always_comb begin
        div_req.start    = (r_state == S_CHK) && mul_rsp.done
                           && !(mul_rsp.ovf || (mul_rsp.product > r_rest));
        div_req.dividend = r_rest;
        div_req.divisor  = r_p;
        if ((r_state == S_DIV || r_state == S_POW) && div_rsp.done
            && div_rsp.remainder == 32'd0) begin
            div_req.start    = 1'b1;
            div_req.dividend = div_rsp.quotient;
        end
    end

    always_comb begin
        mul_req.start = 1'b0;
        mul_req.a     = {32'd0, r_p};
        mul_req.b     = {32'd0, r_p};
        case (r_state)
            S_READ: mul_req.start = 1'b0;
            S_WAIT: mul_req.start = (rd_data >= 32'd2);
            S_TERM: begin
                mul_req.start = (r_mphase == 2'd0);
                mul_req.a     = r_power;
                mul_req.b     = {32'd0, r_p};
            end
            S_SIG: begin
                mul_req.start = (r_mphase == 2'd0);
                mul_req.a     = r_sigma;
                mul_req.b     = r_term;
            end
            S_LEFT: begin
                mul_req.start = (r_mphase == 2'd0);
                mul_req.a     = r_sigma;
                mul_req.b     = r_rest + 64'd1;
            end
            default: mul_req.start = 1'b0;
        endcase
        if (r_state == S_WAIT) begin
            mul_req.a = {32'd0, rd_data};
            mul_req.b = {32'd0, rd_data};
        end
    end

    assign sum = {1'b0, r_term} + {1'b0, mul_rsp.product};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
            r_idx     <= '0;
            r_mphase  <= '0;
        end else begin
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && i_data.req_type == ReqCompute) begin
                        r_n     <= i_data.number;
                        r_rest  <= i_data.number;
                        r_ovf   <= 1'b0;
                        r_idx   <= '0;
                        if (i_data.number < 64'd2) begin
                            r_sigma <= i_data.number;
                            r_state <= S_OUT;
                        end else begin
                            r_sigma <= 64'd1;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    if (r_idx >= limit) begin
                        r_state <= S_LEFT;
                    end else begin
                        r_state <= S_WAIT;
                    end
                    r_mphase <= '0;
                end
                S_WAIT: begin
                    r_p <= rd_data;
                    if (rd_data < 32'd2) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (mul_rsp.done) begin
                        if (mul_rsp.ovf || mul_rsp.product > r_rest) begin
                            r_state <= S_LEFT;
                        end else begin
                            r_state <= S_DIV;
                            r_found <= 1'b0;
                            r_term  <= 64'd1;
                            r_power <= 64'd1;
                        end
                    end
                end
                S_DIV, S_POW: begin
                    if (div_rsp.done) begin
                        if (div_rsp.remainder == 32'd0) begin
                            r_rest   <= div_rsp.quotient;
                            r_found  <= 1'b1;
                            r_state  <= S_TERM;
                            r_mphase <= '0;
                        end else if (r_found) begin
                            r_state  <= S_SIG;
                            r_mphase <= '0;
                        end else begin
                            r_state <= S_NEXT;
                        end
                    end
                end
                S_TERM: begin
                    r_mphase <= 2'd1;
                    if (mul_rsp.done) begin
                        r_power <= mul_rsp.product;
                        r_term  <= sum[63:0];
                        r_ovf   <= r_ovf | mul_rsp.ovf | sum[64];
                        // next division was launched on the quotient already
                        r_state <= S_POW;
                    end
                end
                S_SIG: begin
                    r_mphase <= 2'd1;
                    if (mul_rsp.done) begin
                        r_sigma <= mul_rsp.product;
                        r_ovf   <= r_ovf | mul_rsp.ovf;
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_idx   <= r_idx + IW'(1);
                    r_state <= S_READ;
                end
                S_LEFT: begin
                    if (r_rest <= 64'd1) begin
                        r_state <= S_FIN;
                    end else begin
                        r_mphase <= 2'd1;
                        if (mul_rsp.done && r_mphase == 2'd1) begin
                            r_sigma <= mul_rsp.product;
                            r_ovf   <= r_ovf | mul_rsp.ovf | (&r_rest);
                            r_rest  <= 64'd1;
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_o_valid) begin
                        r_o_data.number_echo <= r_n;
                        r_o_data.divisor_sum <= r_sigma - r_n;
                        r_o_data.wrapped     <= r_ovf | (r_sigma < r_n);
                        r_o_valid            <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule
